[rtl/psc_pkg.sv]
package psc_pkg;

  localparam int OP_W       = 1;
  localparam int TID_W      = 4;
  localparam int ADDR_W     = 32;
  localparam int ACT_W      = 5;
  localparam int CNT_W      = 6;
  localparam logic [ACT_W-1:0] ACTIVE_RESET = 5'd16;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_STORE   = 1'b1;
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_STORE = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [TID_W-1:0] other_thread;
    logic             conflict_kind;
    logic             last;
  } result_t;

endpackage

[rtl/psc_if.sv]
interface psc_in_if;
  logic                        valid;
  logic                        ready;
  logic [psc_pkg::OP_W-1:0]    op;
  logic [psc_pkg::TID_W-1:0]   thread_id;
  logic [psc_pkg::ADDR_W-1:0]  address;

  modport source (output valid, op, thread_id, address, input ready);
  modport sink   (input valid, op, thread_id, address, output ready);
endinterface

interface psc_out_if;
  logic                        valid;
  logic                        ready;
  logic [psc_pkg::TID_W-1:0]   other_thread;
  logic                        conflict_kind;
  logic                        last;

  modport source (output valid, other_thread, conflict_kind, last, input ready);
  modport sink   (input valid, other_thread, conflict_kind, last, output ready);
endinterface

[rtl/psc_ram.sv]
module psc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/psc_pick.sv]
module psc_pick #(
  parameter int N = 32
) (
  input  logic [N-1:0]       pend_i,
  output logic [N-1:0]       low_o,
  output psc_pkg::result_t   res_o
);

  localparam int IW = $clog2(N);

  logic [N-1:0]  low;
  logic [IW-1:0] idx;

  // isolate lowest pending bit, then encode it with an OR per bit
  always_comb begin
    low = pend_i & (~pend_i + N'(1));
    idx = '0;
    for (int j = 0; j < N; j++) begin
      if (low[j]) begin
        idx = idx | IW'(j);
      end
    end
  end

  assign low_o               = low;
  assign res_o.other_thread  = psc_pkg::TID_W'(idx >> 1);
  assign res_o.conflict_kind = idx[0];
  assign res_o.last          = ((pend_i & ~low) == '0);

endmodule

[rtl/page_sharing_conflict_filter.sv]
// Flow: an access is taken in IDLE, which also issues the read of its page row;
//   in READ the row is merged with the access and written back; in SCAN the
//   pending beats go, lowest first, to the output register when it is free.
// No new access is taken until the last beat is in that register.
// Reset: control clears at once; the page memory is then swept to zero, one row
//   per cycle for all 2**PAGE_INDEX_BITS rows, no access taken meanwhile.
module page_sharing_conflict_filter #(
  parameter int THREADS         = 16,
  parameter int PAGE_INDEX_BITS = 20,
  parameter int PAGE_SHIFT      = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [psc_pkg::ACT_W-1:0]  cfg_wdata_i,
  psc_in_if.sink                     in_i,
  psc_out_if.source                  out_o
);

  localparam int ROW_W = 2 * THREADS;
  localparam int DEPTH = 1 << PAGE_INDEX_BITS;
  localparam logic [psc_pkg::CNT_W-1:0] THREADS_C = psc_pkg::CNT_W'(THREADS);

  // Row layout: store-seen bits above load-seen bits, one per thread.
  psc_pkg::state_e state_q, state_d;

  logic [psc_pkg::ACT_W-1:0]  active_q;
  logic [PAGE_INDEX_BITS-1:0] clr_addr_q, clr_addr_d;
  logic [PAGE_INDEX_BITS-1:0] page_q;
  logic                       op_q;
  logic [psc_pkg::TID_W-1:0]  tid_q;
  logic [ROW_W-1:0]           pend_q, pend_d;
  logic                       out_valid_q, out_valid_d;
  psc_pkg::result_t           out_res_q, out_res_d;

  logic [PAGE_INDEX_BITS-1:0] in_page;
  logic [psc_pkg::ADDR_W+PAGE_INDEX_BITS-1:0] addr_ext;
  logic                       tid_ok;
  logic                       in_beat;

  logic                       ram_we, ram_re;
  logic [PAGE_INDEX_BITS-1:0] ram_waddr;
  logic [ROW_W-1:0]           ram_wdata, ram_rdata;

  logic [THREADS-1:0]         own_bit, load_new, store_new, scan_mask;
  logic [psc_pkg::CNT_W-1:0]  limit;
  logic [ROW_W-1:0]           pend_new;

  logic [ROW_W-1:0]           pick_low;
  psc_pkg::result_t           pick_res;
  logic                       out_free;
  logic                       advance;

  // Page index; the zero fill keeps any PAGE_SHIFT up to ADDR_W in range.
  assign addr_ext = {{PAGE_INDEX_BITS{1'b0}}, in_i.address};
  assign in_page  = addr_ext[PAGE_SHIFT +: PAGE_INDEX_BITS];
  assign tid_ok   = ({2'b00, in_i.thread_id} < THREADS_C);
  assign in_beat  = in_i.valid && in_i.ready;

  assign out_free = !out_valid_q || out_o.ready;
  assign advance  = (state_q == psc_pkg::ST_SCAN) && out_free;

  psc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (DEPTH)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (in_page),
    .rdata_o (ram_rdata)
  );

  psc_pick #(
    .N (ROW_W)
  ) u_pick (
    .pend_i (pend_q),
    .low_o  (pick_low),
    .res_o  (pick_res)
  );

  // Merge the access into the row just read and work out the pending beats.
  // Beat order per thread: load match (stores only) before store match.
  always_comb begin
    own_bit   = THREADS'(1) << tid_q;
    load_new  = ram_rdata[THREADS-1:0];
    store_new = ram_rdata[ROW_W-1:THREADS];
    if (op_q == psc_pkg::OP_STORE) begin
      store_new = store_new | own_bit;
    end else begin
      load_new = load_new | own_bit;
    end
    limit = ({1'b0, active_q} > THREADS_C) ? THREADS_C : {1'b0, active_q};
    for (int i = 0; i < THREADS; i++) begin
      scan_mask[i] = (psc_pkg::CNT_W'(i) < limit) &&
                     (psc_pkg::CNT_W'(i) != {2'b00, tid_q});
      pend_new[2*i]   = (op_q == psc_pkg::OP_STORE) && load_new[i] && scan_mask[i];
      pend_new[2*i+1] = store_new[i] && scan_mask[i];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      psc_pkg::ST_CLEAR: begin
        if (clr_addr_q == {PAGE_INDEX_BITS{1'b1}}) begin
          state_d = psc_pkg::ST_IDLE;
        end
      end
      psc_pkg::ST_IDLE: begin
        if (in_beat && tid_ok) begin
          state_d = psc_pkg::ST_READ;
        end
      end
      psc_pkg::ST_READ: begin
        state_d = (pend_new != '0) ? psc_pkg::ST_SCAN : psc_pkg::ST_IDLE;
      end
      psc_pkg::ST_SCAN: begin
        if (out_free && pick_res.last) begin
          state_d = psc_pkg::ST_IDLE;
        end
      end
      default: state_d = psc_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the controller: memory strobes and input readiness.
  always_comb begin
    in_i.ready = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = page_q;
    ram_wdata  = {store_new, load_new};
    unique case (state_q)
      psc_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
        ram_wdata = '0;
      end
      psc_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        ram_re     = in_i.valid && tid_ok;
      end
      psc_pkg::ST_READ: begin
        ram_we = 1'b1;
      end
      psc_pkg::ST_SCAN: begin
      end
      default: begin
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    clr_addr_d  = clr_addr_q + PAGE_INDEX_BITS'(1);
    pend_d      = pend_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_res_d   = out_res_q;
    if (state_q == psc_pkg::ST_READ) begin
      pend_d = pend_new;
    end else if (advance) begin
      // hand the lowest pending beat to the output register and drop it
      pend_d      = pend_q & ~pick_low;
      out_valid_d = 1'b1;
      out_res_d   = pick_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psc_pkg::ST_CLEAR;
      active_q    <= psc_pkg::ACTIVE_RESET;
      clr_addr_q  <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      if (state_q == psc_pkg::ST_CLEAR) begin
        clr_addr_q <= clr_addr_d;
      end
    end
  end

  // Payload registers: hold the accepted access and the offered beat.
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      page_q <= in_page;
      op_q   <= in_i.op;
      tid_q  <= in_i.thread_id;
    end
    out_res_q <= out_res_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.other_thread  = out_res_q.other_thread;
  assign out_o.conflict_kind = out_res_q.conflict_kind;
  assign out_o.last          = out_res_q.last;

endmodule
